[hdl/pelc_pkg.sv]
// ----------------------------------------------------------------------------
// pelc_pkg
// Shared types and constants for the priority/expiry LRU cache core.
// ----------------------------------------------------------------------------
package pelc_pkg;

	localparam int SLOTS = 16;
	localparam int RW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);

	localparam logic [1:0] REQ_GET    = 2'd0;
	localparam logic [1:0] REQ_SET    = 2'd1;
	localparam logic [1:0] REQ_TRIM   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [0:0] REG_MAX_ITEMS = 1'b0;

	typedef logic [RW-1:0] rank_t;

	// Victim candidate handed along the cell chain.
	typedef struct packed {
		logic        found;
		logic [31:0] expiry;
		logic [15:0] priority_v;
		rank_t       rank;
		rank_t       slot;
	} cand_t;

	// Broadcast command from the controller to every cell.
	typedef struct packed {
		logic        match_en;
		logic        hit_en;
		logic        insert_en;
		rank_t       insert_slot;
		logic        drop_en;
		rank_t       drop_slot;
		rank_t       drop_rank;
		logic        recent_en;
		rank_t       recent_rank;
		logic        shift_all;
		logic        scan_exp;
		logic        scan_pri;
		logic [31:0] min_exp;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] req_key;
		logic [31:0] req_value;
		logic [15:0] req_priority;
		logic [31:0] req_expiry;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
		logic [4:0]  evicted_count;
		logic [4:0]  occupancy;
	} rsp_t;

endpackage

[hdl/pelc_if.sv]
// ----------------------------------------------------------------------------
// pelc_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface pelc_req_if;
	logic          valid;
	logic          ready;
	pelc_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pelc_rsp_if;
	logic          valid;
	logic          ready;
	pelc_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/pelc_cell.sv]
// ----------------------------------------------------------------------------
// pelc_cell
// One slot: holds an entry, compares its key, keeps its age rank and merges
// itself into the victim candidate passed from its neighbor, registering the
// merged candidate for the next cell.
// ----------------------------------------------------------------------------
module pelc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  pelc_pkg::rank_t   idx,
	input  pelc_pkg::cmd_t    cmd,
	input  pelc_pkg::req_t    req,
	input  pelc_pkg::cand_t   cand_in,
	output pelc_pkg::cand_t   cand_out,
	output logic              valid,
	output logic              match,
	output logic [31:0]       data_out,
	output logic [31:0]       expiry_out,
	output pelc_pkg::rank_t   rank_out
);
	logic                valid_q;
	logic [31:0]         key_q;
	logic [31:0]         data_q;
	logic [15:0]         pri_q;
	logic [31:0]         exp_q;
	pelc_pkg::rank_t     rank_q;
	pelc_pkg::cand_t     cand_q;
	pelc_pkg::cand_t     cand_nxt;
	logic                take;

	assign valid      = valid_q;
	assign match      = valid_q && key_q == req.req_key;
	assign data_out   = data_q;
	assign expiry_out = exp_q;
	assign rank_out   = rank_q;
	assign cand_out   = cand_q;

	always_comb begin
		take = 1'b0;
		if (valid_q) begin
			if (cmd.scan_exp) begin
				take = exp_q == cmd.min_exp && (!cand_in.found || rank_q > cand_in.rank);
			end else if (cmd.scan_pri) begin
				take = !cand_in.found || pri_q < cand_in.priority_v ||
					(pri_q == cand_in.priority_v && rank_q > cand_in.rank);
			end
		end
		cand_nxt = cand_in;
		if (take) begin
			cand_nxt.found      = 1'b1;
			cand_nxt.expiry     = exp_q;
			cand_nxt.priority_v = pri_q;
			cand_nxt.rank       = rank_q;
			cand_nxt.slot       = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= cand_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (cmd.insert_en && cmd.insert_slot == idx) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
				key_q   <= req.req_key;
				data_q  <= req.req_value;
				pri_q   <= req.req_priority;
				exp_q   <= req.req_expiry;
			end else if (valid_q) begin
				if (cmd.shift_all) begin
					rank_q <= rank_q + 1'b1;
				end else if (cmd.recent_en) begin
					if (match) begin
						rank_q <= '0;
						if (cmd.hit_en) begin
							key_q  <= req.req_key;
							data_q <= req.req_value;
							pri_q  <= req.req_priority;
							exp_q  <= req.req_expiry;
						end
					end else if (rank_q < cmd.recent_rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end else if (cmd.drop_en) begin
					if (cmd.drop_slot == idx) begin
						valid_q <= 1'b0;
					end else if (rank_q > cmd.drop_rank) begin
						rank_q <= rank_q - 1'b1;
					end
				end
			end
		end
	end

endmodule

[hdl/pelc_ctrl.sv]
// ----------------------------------------------------------------------------
// pelc_ctrl
// Request sequencer: lookup, insert, then one victim per eviction round
// (expiry min pass, then tie/priority pass over the cell chain).
// ----------------------------------------------------------------------------
module pelc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [3:0]                    max_items,
	pelc_req_if.sink                      req_ch,
	pelc_rsp_if.source                    rsp_ch,
	output pelc_pkg::cmd_t                cmd,
	output pelc_pkg::req_t                req,
	input  logic [pelc_pkg::SLOTS-1:0]    valid_v,
	input  logic [pelc_pkg::SLOTS-1:0]    match_v,
	input  logic [31:0]                   data_v [pelc_pkg::SLOTS],
	input  logic [31:0]                   exp_v [pelc_pkg::SLOTS],
	input  pelc_pkg::cand_t               chain_end,
	input  pelc_pkg::rank_t               match_rank
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_MIN  = 3'd3;
	localparam logic [2:0] ST_PICK = 3'd4;
	localparam logic [2:0] ST_DROP = 3'd5;
	localparam logic [2:0] ST_RSP  = 3'd6;

	logic [2:0]             state_q;
	pelc_pkg::req_t         req_q;
	pelc_pkg::rsp_t         rsp_q;
	logic [4:0]             ev_q;
	logic                   forced_q;
	logic [31:0]            minexp_q;
	logic                   expired_q;
	pelc_pkg::rank_t        idx_q;
	logic [pelc_pkg::CW-1:0] occ;
	logic                   any_match;
	pelc_pkg::rank_t        match_slot, free_slot;
	logic                   over;

	assign req          = req_q;
	assign req_ch.ready = state_q == ST_IDLE;
	assign rsp_ch.valid = state_q == ST_RSP;
	assign rsp_ch.data  = rsp_q;
	assign any_match    = |match_v;
	assign over         = forced_q ? (occ >= pelc_pkg::CW'(pelc_pkg::SLOTS))
		: (occ > pelc_pkg::CW'(max_items));

	always_comb begin
		occ = '0;
		match_slot = '0;
		free_slot = '0;
		for (int i = pelc_pkg::SLOTS - 1; i >= 0; i--) begin
			occ = occ + pelc_pkg::CW'(valid_v[i]);
			if (match_v[i]) match_slot = pelc_pkg::rank_t'(i);
			if (!valid_v[i]) free_slot = pelc_pkg::rank_t'(i);
		end
	end

	always_comb begin
		cmd = '0;
		cmd.min_exp = minexp_q;
		cmd.recent_rank = match_rank;
		cmd.insert_slot = free_slot;
		cmd.drop_slot = chain_end.slot;
		cmd.drop_rank = chain_end.rank;
		case (state_q)
			ST_LOOK: begin
				if ((req_q.req_type == pelc_pkg::REQ_GET ||
					req_q.req_type == pelc_pkg::REQ_SET) && any_match) begin
					cmd.recent_en = 1'b1;
					cmd.hit_en = req_q.req_type == pelc_pkg::REQ_SET;
				end else if (req_q.req_type == pelc_pkg::REQ_SET && !forced_q &&
					occ < pelc_pkg::CW'(pelc_pkg::SLOTS)) begin
					cmd.insert_en = 1'b1;
					cmd.shift_all = 1'b1;
				end
			end
			ST_PICK: begin
				cmd.scan_exp = expired_q;
				cmd.scan_pri = !expired_q;
			end
			ST_DROP: cmd.drop_en = 1'b1;
			default: ;
		endcase
	end

	// shift_all and insert in the same cycle: the inserted cell takes insert first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			forced_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_ch.valid) begin
						req_q    <= req_ch.data;
						ev_q     <= '0;
						rsp_q    <= '0;
						forced_q <= 1'b0;
						state_q  <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (req_q.req_type == pelc_pkg::REQ_GET) begin
						if (any_match) begin
							rsp_q.hit <= 1'b1;
							rsp_q.read_value <= data_v[match_slot];
						end
						state_q <= ST_CHK;
						forced_q <= 1'b0;
					end else if (req_q.req_type == pelc_pkg::REQ_SET && !any_match &&
						!forced_q && occ >= pelc_pkg::CW'(pelc_pkg::SLOTS)) begin
						forced_q <= 1'b1;
						state_q  <= ST_CHK;
					end else begin
						forced_q <= 1'b0;
						state_q  <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (req_q.req_type == pelc_pkg::REQ_GET ||
						req_q.req_type == pelc_pkg::REQ_UNUSED || !over) begin
						state_q <= forced_q ? ST_LOOK : ST_RSP;
						forced_q <= 1'b0;
						rsp_q.evicted_count <= ev_q;
						rsp_q.occupancy <= 5'(occ);
					end else begin
						idx_q <= '0;
						minexp_q <= 32'hFFFFFFFF;
						state_q <= ST_MIN;
					end
				end
				ST_MIN: begin
					if (valid_v[idx_q] && exp_v[idx_q] < minexp_q) minexp_q <= exp_v[idx_q];
					if (idx_q == pelc_pkg::rank_t'(pelc_pkg::SLOTS - 1)) begin
						idx_q <= '0;
						expired_q <= ((valid_v[idx_q] && exp_v[idx_q] < minexp_q)
							? exp_v[idx_q] : minexp_q) <= req_q.now;
						state_q <= ST_PICK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				// candidate ripples one cell per cycle down the registered chain
				ST_PICK: begin
					if (idx_q == pelc_pkg::rank_t'(pelc_pkg::SLOTS - 1)) begin
						idx_q <= '0;
						state_q <= ST_DROP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DROP: begin
					ev_q <= ev_q + 1'b1;
					state_q <= ST_CHK;
				end
				ST_RSP: begin
					if (rsp_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/priority_expiry_lru_cache_core.sv]
// ----------------------------------------------------------------------------
// priority_expiry_lru_cache_core
// Key-value cache with LRU order, priority and expiry based eviction.
// ----------------------------------------------------------------------------
// Channels: req (valid/ready) takes one item with type, key, value, priority,
// expiry and current time; rsp (valid/ready) returns hit, value, evicted count
// and occupancy. One item is in work at a time; req.ready is high only idle.
// Without eviction an item is looked up and checked before its result is
// offered. Each eviction adds a round: an expiry min scan of one slot per
// cycle, the victim rippling down the registered cell chain, a drop and a
// recheck. A set of a new key into a full table adds one such round plus a
// repeated lookup before its insert.
// max_items is written over the APB port at address 0; the user must write
// it only while idle, the block itself does not enforce this.
// Reset empties the table and clears max_items. A stalled rsp holds its item
// and no new request is taken until it is delivered.
// ----------------------------------------------------------------------------
module priority_expiry_lru_cache_core (
	input  logic        clk,
	input  logic        arst_n,
	pelc_req_if.sink    req,
	pelc_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [3:0]                     max_items_q;
	pelc_pkg::cmd_t                 cmd;
	pelc_pkg::req_t                 req_q;
	pelc_pkg::cand_t                chain [pelc_pkg::SLOTS+1];
	logic [pelc_pkg::SLOTS-1:0]     valid_v, match_v;
	logic [31:0]                    data_v [pelc_pkg::SLOTS];
	logic [31:0]                    exp_v [pelc_pkg::SLOTS];
	pelc_pkg::rank_t                rank_v [pelc_pkg::SLOTS];
	pelc_pkg::rank_t                match_rank;

	assign pready = 1'b1;
	assign prdata = (paddr == pelc_pkg::REG_MAX_ITEMS) ? {28'd0, max_items_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_items_q <= '0;
		end else if (psel && penable && pwrite && paddr == pelc_pkg::REG_MAX_ITEMS) begin
			max_items_q <= pwdata[3:0];
		end
	end

	assign chain[0] = '0;

	// keys are unique, so at most one cell matches
	always_comb begin
		match_rank = '0;
		for (int i = 0; i < pelc_pkg::SLOTS; i++)
			if (match_v[i]) match_rank = rank_v[i];
	end

	for (genvar g = 0; g < pelc_pkg::SLOTS; g++) begin : g_cell
		pelc_cell u_cell (
			.clk(clk), .arst_n(arst_n), .idx(pelc_pkg::rank_t'(g)), .cmd(cmd),
			.req(req_q), .cand_in(chain[g]), .cand_out(chain[g+1]),
			.valid(valid_v[g]), .match(match_v[g]), .data_out(data_v[g]),
			.expiry_out(exp_v[g]), .rank_out(rank_v[g])
		);
	end

	pelc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .max_items(max_items_q), .req_ch(req), .rsp_ch(rsp),
		.cmd(cmd), .req(req_q), .valid_v(valid_v), .match_v(match_v), .data_v(data_v),
		.exp_v(exp_v), .chain_end(chain[pelc_pkg::SLOTS]), .match_rank(match_rank)
	);

endmodule
